### rtl/core/tmpc_pkg.sv
// ============================================================================
// tmpc_pkg - shared types and constants for the triangle mesh point corrector
// Item kinds, sequencer states and the layout of one stored triangle map.
// ============================================================================
`default_nettype none

package tmpc_pkg;

  localparam int MAX_TRIANGLES_DEF = 64;
  localparam int FRAC_BITS_DEF     = 16;
  localparam int COORD_W           = 32;

  // item kinds
  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_LOAD  = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;

  // vertex that completes a triangle
  localparam logic [1:0] VTX_LAST = 2'd2;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_EDGE,
    S_DET0,
    S_DET1,
    S_STORE,
    S_RD,
    S_DX,
    S_M0,
    S_M1,
    S_M2,
    S_M3,
    S_N,
    S_SIGN,
    S_CHK,
    S_FDIV,
    S_P0,
    S_P1,
    S_P2,
    S_P3,
    S_P4,
    S_ACC,
    S_NEXT,
    S_FIN,
    S_AVG,
    S_EMIT
  } state_t;

  // one triangle map: reference origin, adjugate rows, determinant,
  // target origin and target edges
  typedef struct packed {
    logic signed [COORD_W-1:0]   ro_x;
    logic signed [COORD_W-1:0]   ro_y;
    logic signed [COORD_W-1:0]   iv00;
    logic signed [COORD_W-1:0]   iv01;
    logic signed [COORD_W-1:0]   iv10;
    logic signed [COORD_W-1:0]   iv11;
    logic signed [2*COORD_W-1:0] det;
    logic signed [COORD_W-1:0]   to_x;
    logic signed [COORD_W-1:0]   to_y;
    logic signed [COORD_W-1:0]   te0x;
    logic signed [COORD_W-1:0]   te0y;
    logic signed [COORD_W-1:0]   te1x;
    logic signed [COORD_W-1:0]   te1y;
  } entry_t;

endpackage

`default_nettype wire

### rtl/core/tmpc_if.sv
// ============================================================================
// tmpc_if - word channels of the triangle mesh point corrector
// Input channel (clear, load and query words) and result channel.
// ============================================================================
`default_nettype none

interface tmpc_in_if;
  logic                  valid;
  logic                  ready;
  logic [1:0]            kind;
  logic [1:0]            vertex_index;
  tmpc_pkg::coord_t      ref_x;
  tmpc_pkg::coord_t      ref_y;
  tmpc_pkg::coord_t      target_x;
  tmpc_pkg::coord_t      target_y;
  tmpc_pkg::coord_t      point_x;
  tmpc_pkg::coord_t      point_y;

  modport source (output valid, kind, vertex_index, ref_x, ref_y, target_x, target_y,
                  point_x, point_y, input ready);
  modport sink   (input valid, kind, vertex_index, ref_x, ref_y, target_x, target_y,
                  point_x, point_y, output ready);
endinterface

interface tmpc_out_if #(
  parameter int CNT_W = 7
);
  logic               valid;
  logic               ready;
  tmpc_pkg::coord_t   out_x;
  tmpc_pkg::coord_t   out_y;
  logic [CNT_W-1:0]   hit_count;
  logic [CNT_W-1:0]   table_size;

  modport source (output valid, out_x, out_y, hit_count, table_size, input ready);
  modport sink   (input valid, out_x, out_y, hit_count, table_size, output ready);
endinterface

`default_nettype wire

### rtl/core/tmpc_fracdiv.sv
// ============================================================================
// tmpc_fracdiv - serial fraction divider
// quot = floor(num * 2^FRAC_BITS / den) for num <= den, one bit per cycle.
// ============================================================================
`default_nettype none

module tmpc_fracdiv #(
  parameter int FRAC_BITS = tmpc_pkg::FRAC_BITS_DEF,
  parameter int W         = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [W-1:0]       num,
  input  wire logic [W-1:0]       den,
  output logic                    done,
  output logic [FRAC_BITS:0]      quot
);

  localparam int CW = $clog2(FRAC_BITS + 1);

  logic            busy_r;
  logic            done_r;
  logic [CW-1:0]   cnt_r;
  logic [W-1:0]    rem_r;
  logic [W-1:0]    den_r;
  logic [FRAC_BITS:0] q_r;
  logic [W:0]      sh;
  logic            ge;

  assign sh = {rem_r, 1'b0};
  assign ge = (num >= den);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(FRAC_BITS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      q_r   <= {{FRAC_BITS{1'b0}}, ge};
      rem_r <= ge ? (num - den) : num;
    end else if (busy_r) begin
      if (sh >= {1'b0, den_r}) begin
        rem_r <= W'(sh - {1'b0, den_r});
        q_r   <= {q_r[FRAC_BITS-1:0], 1'b1};
      end else begin
        rem_r <= sh[W-1:0];
        q_r   <= {q_r[FRAC_BITS-1:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

`default_nettype wire

### rtl/core/tmpc_avgdiv.sv
// ============================================================================
// tmpc_avgdiv - serial signed divider for the hit average
// Restoring division by an unsigned count, truncated toward zero.
// ============================================================================
`default_nettype none

module tmpc_avgdiv #(
  parameter int NUM_W = 42,
  parameter int DEN_W = 7
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic signed [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0]        den,
  output logic                         done,
  output logic signed [NUM_W-1:0]      quot
);

  localparam int CW = $clog2(NUM_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CW-1:0]    cnt_r;
  logic             neg_r;
  logic [NUM_W-1:0] q_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   sh;

  assign sh = {rem_r, q_r[NUM_W-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= num[NUM_W-1];
      q_r   <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      if (sh >= {1'b0, den_r}) begin
        rem_r <= DEN_W'(sh - {1'b0, den_r});
        q_r   <= {q_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_r <= sh[DEN_W-1:0];
        q_r   <= {q_r[NUM_W-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign quot = neg_r ? -$signed(q_r) : $signed(q_r);

endmodule

`default_nettype wire

### rtl/core/triangle_mesh_point_corrector_unit.sv
// ============================================================================
// triangle_mesh_point_corrector_unit - piecewise affine point correction
// Triangle map table in one synchronous memory, walked entry by entry per query.
// ============================================================================
// Clear and vertex 0/1 load words finish in S_IDLE; a vertex 2 load runs S_EDGE,
//   S_DET0, S_DET1 and S_STORE. A query walks each stored triangle, a hit also
//   through the fraction dividers, then the average divider when anything hit,
//   and then the output register.
// One word at a time; rate is set by the per-entry memory walk and the
//   shared 32x32 multiplier. A new word is taken while a result waits.
// Reset clears the table count and the control; the map memory and the
//   pending vertices are not cleared and are valid only once written.
`default_nettype none

module triangle_mesh_point_corrector_unit #(
  parameter int MAX_TRIANGLES = tmpc_pkg::MAX_TRIANGLES_DEF,
  parameter int FRAC_BITS     = tmpc_pkg::FRAC_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  tmpc_in_if.sink    in_ch,
  tmpc_out_if.source out_ch
);

  localparam int CNT_W = $clog2(MAX_TRIANGLES + 1);
  localparam int IDX_W = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
  localparam int MAP_W = 35;              // one mapped coordinate
  localparam int ACC_W = MAP_W + CNT_W;   // sum over all hits
  localparam int L_W   = FRAC_BITS + 1;   // barycentric weight
  localparam int N_W   = 65;              // adjugate row times offset

  // clamp an edge or offset to +/-(2^31-1)
  function automatic tmpc_pkg::coord_t sat31(input logic signed [32:0] v);
    if (v > 33'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -33'sd2147483647) begin
      return 32'sh80000001;
    end
    return v[31:0];
  endfunction

  function automatic tmpc_pkg::coord_t sat32(input logic signed [ACC_W-1:0] v);
    if (v > ACC_W'(32'sh7fffffff)) begin
      return 32'sh7fffffff;
    end else if (v < ACC_W'(32'sh80000000)) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  tmpc_pkg::state_t state_r, state_nxt;

  logic               in_acc;
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   k_r;
  logic [CNT_W-1:0]   hits_r;

  // held vertices 0 and 1
  tmpc_pkg::coord_t   pend_rx [2];
  tmpc_pkg::coord_t   pend_ry [2];
  tmpc_pkg::coord_t   pend_tx [2];
  tmpc_pkg::coord_t   pend_ty [2];

  // latched word payload
  tmpc_pkg::coord_t   r2x_r, r2y_r, t2x_r, t2y_r, px_r, py_r;

  // edges of the triangle being stored
  tmpc_pkg::coord_t   e00_r, e10_r, e01_r, e11_r;
  tmpc_pkg::coord_t   g0x_r, g0y_r, g1x_r, g1y_r;

  // shared multiplier
  tmpc_pkg::coord_t   mul_a, mul_b;
  logic signed [63:0] prod_r;
  logic signed [63:0] p1_r;
  logic signed [63:0] det_w;

  // map memory
  tmpc_pkg::entry_t   mem [MAX_TRIANGLES];
  tmpc_pkg::entry_t   rd_r;
  tmpc_pkg::entry_t   wentry;
  logic               mem_we;

  // per-entry query datapath
  tmpc_pkg::coord_t    dx_r, dy_r;
  logic signed [N_W-1:0] n0_r, n1_r;
  logic [63:0]         d_r;
  logic                hit;
  logic signed [N_W-1:0] mx_r, my_r;
  logic signed [N_W-1:0] mx_sh, my_sh;
  logic signed [MAP_W-1:0] mapx, mapy;
  logic signed [ACC_W-1:0] accx_r, accy_r;

  // dividers
  logic               fd_start;
  logic               fd0_done, fd1_done;
  logic [L_W-1:0]     l0, l1;
  tmpc_pkg::coord_t   l0_ext, l1_ext;
  logic               av_start;
  logic               avx_done, avy_done;
  logic signed [ACC_W-1:0] avx_q, avy_q;

  // result register
  logic               ovalid_r;
  tmpc_pkg::coord_t   rx_r, ry_r;
  tmpc_pkg::coord_t   ox_r, oy_r;
  logic [CNT_W-1:0]   ohit_r, osize_r;
  logic               out_load;

  assign in_ch.ready = (state_r == tmpc_pkg::S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_load    = (state_r == tmpc_pkg::S_EMIT) && (!ovalid_r || out_ch.ready);

  assign l0_ext = tmpc_pkg::coord_t'({{(32-L_W){1'b0}}, l0});
  assign l1_ext = tmpc_pkg::coord_t'({{(32-L_W){1'b0}}, l1});

  assign det_w = p1_r - prod_r;
  assign hit   = !n0_r[N_W-1] && !n1_r[N_W-1] &&
                 (({1'b0, n0_r[63:0]} + {1'b0, n1_r[63:0]}) <= {1'b0, d_r});

  assign mx_sh = mx_r >>> FRAC_BITS;
  assign my_sh = my_r >>> FRAC_BITS;
  assign mapx  = MAP_W'(rd_r.to_x) + MAP_W'(mx_sh);
  assign mapy  = MAP_W'(rd_r.to_y) + MAP_W'(my_sh);

  assign fd_start = (state_r == tmpc_pkg::S_CHK) && hit;
  assign av_start = (state_r == tmpc_pkg::S_FIN) && (hits_r != '0);
  assign mem_we   = (state_r == tmpc_pkg::S_STORE) && (det_w != '0) &&
                    (count_r < CNT_W'(MAX_TRIANGLES));

  always_comb begin
    wentry      = rd_r;
    wentry.ro_x = pend_rx[0];
    wentry.ro_y = pend_ry[0];
    wentry.iv00 = e11_r;
    wentry.iv01 = -e01_r;
    wentry.iv10 = -e10_r;
    wentry.iv11 = e00_r;
    wentry.det  = det_w;
    wentry.to_x = pend_tx[0];
    wentry.to_y = pend_ty[0];
    wentry.te0x = g0x_r;
    wentry.te0y = g0y_r;
    wentry.te1x = g1x_r;
    wentry.te1y = g1y_r;
  end

  // operand select for the one multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      tmpc_pkg::S_DET0: begin mul_a = e00_r;     mul_b = e11_r;  end
      tmpc_pkg::S_DET1: begin mul_a = e01_r;     mul_b = e10_r;  end
      tmpc_pkg::S_M0:   begin mul_a = rd_r.iv00; mul_b = dx_r;   end
      tmpc_pkg::S_M1:   begin mul_a = rd_r.iv01; mul_b = dy_r;   end
      tmpc_pkg::S_M2:   begin mul_a = rd_r.iv10; mul_b = dx_r;   end
      tmpc_pkg::S_M3:   begin mul_a = rd_r.iv11; mul_b = dy_r;   end
      tmpc_pkg::S_P0:   begin mul_a = rd_r.te0x; mul_b = l0_ext; end
      tmpc_pkg::S_P1:   begin mul_a = rd_r.te1x; mul_b = l1_ext; end
      tmpc_pkg::S_P2:   begin mul_a = rd_r.te0y; mul_b = l0_ext; end
      tmpc_pkg::S_P3:   begin mul_a = rd_r.te1y; mul_b = l1_ext; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // map memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count_r[IDX_W-1:0]] <= wentry;
    end
    rd_r <= mem[k_r[IDX_W-1:0]];
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tmpc_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tmpc_pkg::S_IDLE: begin
        if (in_acc) begin
          case (in_ch.kind)
            tmpc_pkg::KIND_LOAD: begin
              if (in_ch.vertex_index == tmpc_pkg::VTX_LAST) state_nxt = tmpc_pkg::S_EDGE;
            end
            tmpc_pkg::KIND_QUERY: begin
              state_nxt = (count_r == '0) ? tmpc_pkg::S_FIN : tmpc_pkg::S_RD;
            end
            default: ;
          endcase
        end
      end
      tmpc_pkg::S_EDGE:  state_nxt = tmpc_pkg::S_DET0;
      tmpc_pkg::S_DET0:  state_nxt = tmpc_pkg::S_DET1;
      tmpc_pkg::S_DET1:  state_nxt = tmpc_pkg::S_STORE;
      tmpc_pkg::S_STORE: state_nxt = tmpc_pkg::S_IDLE;
      tmpc_pkg::S_RD:    state_nxt = tmpc_pkg::S_DX;
      tmpc_pkg::S_DX:    state_nxt = tmpc_pkg::S_M0;
      tmpc_pkg::S_M0:    state_nxt = tmpc_pkg::S_M1;
      tmpc_pkg::S_M1:    state_nxt = tmpc_pkg::S_M2;
      tmpc_pkg::S_M2:    state_nxt = tmpc_pkg::S_M3;
      tmpc_pkg::S_M3:    state_nxt = tmpc_pkg::S_N;
      tmpc_pkg::S_N:     state_nxt = tmpc_pkg::S_SIGN;
      tmpc_pkg::S_SIGN:  state_nxt = tmpc_pkg::S_CHK;
      tmpc_pkg::S_CHK:   state_nxt = hit ? tmpc_pkg::S_FDIV : tmpc_pkg::S_NEXT;
      tmpc_pkg::S_FDIV:  if (fd0_done) state_nxt = tmpc_pkg::S_P0;
      tmpc_pkg::S_P0:    state_nxt = tmpc_pkg::S_P1;
      tmpc_pkg::S_P1:    state_nxt = tmpc_pkg::S_P2;
      tmpc_pkg::S_P2:    state_nxt = tmpc_pkg::S_P3;
      tmpc_pkg::S_P3:    state_nxt = tmpc_pkg::S_P4;
      tmpc_pkg::S_P4:    state_nxt = tmpc_pkg::S_ACC;
      tmpc_pkg::S_ACC:   state_nxt = tmpc_pkg::S_NEXT;
      tmpc_pkg::S_NEXT: begin
        state_nxt = ((k_r + 1'b1) == count_r) ? tmpc_pkg::S_FIN : tmpc_pkg::S_RD;
      end
      tmpc_pkg::S_FIN:   state_nxt = (hits_r == '0) ? tmpc_pkg::S_EMIT : tmpc_pkg::S_AVG;
      tmpc_pkg::S_AVG:   if (avx_done) state_nxt = tmpc_pkg::S_EMIT;
      tmpc_pkg::S_EMIT:  if (out_load) state_nxt = tmpc_pkg::S_IDLE;
      default:           state_nxt = tmpc_pkg::S_IDLE;
    endcase
  end

  // control counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      k_r     <= '0;
      hits_r  <= '0;
    end else begin
      if (in_acc) begin
        k_r    <= '0;
        hits_r <= '0;
        if (in_ch.kind == tmpc_pkg::KIND_CLEAR) count_r <= '0;
      end
      if (mem_we) count_r <= count_r + 1'b1;
      if (state_r == tmpc_pkg::S_NEXT) k_r <= k_r + 1'b1;
      if (state_r == tmpc_pkg::S_ACC) hits_r <= hits_r + 1'b1;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      r2x_r  <= in_ch.ref_x;
      r2y_r  <= in_ch.ref_y;
      t2x_r  <= in_ch.target_x;
      t2y_r  <= in_ch.target_y;
      px_r   <= in_ch.point_x;
      py_r   <= in_ch.point_y;
      accx_r <= '0;
      accy_r <= '0;
      if (in_ch.kind == tmpc_pkg::KIND_LOAD && !in_ch.vertex_index[1]) begin
        pend_rx[in_ch.vertex_index[0]] <= in_ch.ref_x;
        pend_ry[in_ch.vertex_index[0]] <= in_ch.ref_y;
        pend_tx[in_ch.vertex_index[0]] <= in_ch.target_x;
        pend_ty[in_ch.vertex_index[0]] <= in_ch.target_y;
      end
    end
    case (state_r)
      tmpc_pkg::S_EDGE: begin
        e00_r <= sat31(33'(pend_rx[1]) - 33'(pend_rx[0]));
        e10_r <= sat31(33'(pend_ry[1]) - 33'(pend_ry[0]));
        e01_r <= sat31(33'(r2x_r) - 33'(pend_rx[0]));
        e11_r <= sat31(33'(r2y_r) - 33'(pend_ry[0]));
        g0x_r <= sat31(33'(pend_tx[1]) - 33'(pend_tx[0]));
        g0y_r <= sat31(33'(pend_ty[1]) - 33'(pend_ty[0]));
        g1x_r <= sat31(33'(t2x_r) - 33'(pend_tx[0]));
        g1y_r <= sat31(33'(t2y_r) - 33'(pend_ty[0]));
      end
      tmpc_pkg::S_DET1: p1_r <= prod_r;
      tmpc_pkg::S_DX: begin
        dx_r <= sat31(33'(px_r) - 33'(rd_r.ro_x));
        dy_r <= sat31(33'(py_r) - 33'(rd_r.ro_y));
      end
      tmpc_pkg::S_M1: n0_r <= N_W'(prod_r);
      tmpc_pkg::S_M2: n0_r <= n0_r + N_W'(prod_r);
      tmpc_pkg::S_M3: n1_r <= N_W'(prod_r);
      tmpc_pkg::S_N:  n1_r <= n1_r + N_W'(prod_r);
      tmpc_pkg::S_SIGN: begin
        // fold a negative determinant into the numerators
        if (rd_r.det[63]) begin
          n0_r <= -n0_r;
          n1_r <= -n1_r;
          d_r  <= 64'(-rd_r.det);
        end else begin
          d_r  <= 64'(rd_r.det);
        end
      end
      tmpc_pkg::S_P1: mx_r <= N_W'(prod_r);
      tmpc_pkg::S_P2: mx_r <= mx_r + N_W'(prod_r);
      tmpc_pkg::S_P3: begin
        my_r   <= N_W'(prod_r);
        accx_r <= accx_r + ACC_W'(mapx);
      end
      tmpc_pkg::S_P4:  my_r <= my_r + N_W'(prod_r);
      tmpc_pkg::S_ACC: accy_r <= accy_r + ACC_W'(mapy);
      tmpc_pkg::S_FIN: begin
        rx_r <= px_r;
        ry_r <= py_r;
      end
      tmpc_pkg::S_AVG: begin
        if (avx_done) begin
          rx_r <= sat32(avx_q);
          ry_r <= sat32(avy_q);
        end
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (out_load) begin
      ovalid_r <= 1'b1;
    end else if (out_ch.ready) begin
      ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      ox_r    <= rx_r;
      oy_r    <= ry_r;
      ohit_r  <= hits_r;
      osize_r <= count_r;
    end
  end

  assign out_ch.valid      = ovalid_r;
  assign out_ch.out_x      = ox_r;
  assign out_ch.out_y      = oy_r;
  assign out_ch.hit_count  = ohit_r;
  assign out_ch.table_size = osize_r;

  tmpc_fracdiv #(.FRAC_BITS(FRAC_BITS), .W(64)) u_fdiv0 (
    .clk   (clk),
    .rst_n (rst_n),
    .start (fd_start),
    .num   (n0_r[63:0]),
    .den   (d_r),
    .done  (fd0_done),
    .quot  (l0)
  );

  tmpc_fracdiv #(.FRAC_BITS(FRAC_BITS), .W(64)) u_fdiv1 (
    .clk   (clk),
    .rst_n (rst_n),
    .start (fd_start),
    .num   (n1_r[63:0]),
    .den   (d_r),
    .done  (fd1_done),
    .quot  (l1)
  );

  tmpc_avgdiv #(.NUM_W(ACC_W), .DEN_W(CNT_W)) u_avgx (
    .clk   (clk),
    .rst_n (rst_n),
    .start (av_start),
    .num   (accx_r),
    .den   (hits_r),
    .done  (avx_done),
    .quot  (avx_q)
  );

  tmpc_avgdiv #(.NUM_W(ACC_W), .DEN_W(CNT_W)) u_avgy (
    .clk   (clk),
    .rst_n (rst_n),
    .start (av_start),
    .num   (accy_r),
    .den   (hits_r),
    .done  (avy_done),
    .quot  (avy_q)
  );

  // ---- assertions ----
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_TRIANGLES))
    else $error("table count above capacity");

  a_hits_le_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.hit_count <= out_ch.table_size))
    else $error("hit count above table size");

  a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tmpc_pkg::S_RD) |-> (k_r < count_r))
    else $error("walk index beyond stored entries");

  a_fdiv_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    fd0_done == fd1_done)
    else $error("fraction dividers out of step");

  a_avg_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    avx_done == avy_done)
    else $error("average dividers out of step");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.kind == tmpc_pkg::KIND_CLEAR) |=> (count_r == '0))
    else $error("clear did not empty table");

endmodule

`default_nettype wire

### test/tb_top.sv
// ============================================================================
// tb_top - testbench for the triangle mesh point corrector unit
// Drives clear, load and query words with random gaps and stalls, predicts
// every corrected point in a local model of the triangle map table and checks
// each result word field by field in arrival order.
// ============================================================================
`default_nettype none

module tb_top;

  typedef tmpc_pkg::coord_t coord_t;

  localparam int  N_TRI    = tmpc_pkg::MAX_TRIANGLES_DEF;
  localparam int  FRAC     = tmpc_pkg::FRAC_BITS_DEF;
  localparam longint LIM31 = 64'sd2147483647;
  localparam longint ONE_Q = longint'(1) << FRAC;
  localparam int  CYCLE_LIMIT = 8000000;

  logic clk;
  logic rst_n;

  tmpc_in_if       in_ch ();
  tmpc_out_if #(7) out_ch ();

  triangle_mesh_point_corrector_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // one expected result word
  typedef struct {
    coord_t     x;
    coord_t     y;
    logic [6:0] hits;
    logic [6:0] size;
  } corr_t;

  corr_t corr_q[$];

  // local copy of the triangle map table
  longint ro[N_TRI][2];
  longint inv0[N_TRI][2];
  longint inv1[N_TRI][2];
  longint det_t[N_TRI];
  longint tgo[N_TRI][2];
  longint te0[N_TRI][2];
  longint te1[N_TRI][2];
  longint pend_ref[2][2];
  longint pend_tgt[2][2];
  int     tri_count;

  int n_mismatch, n_results, n_queries, n_hit_queries, n_loads, n_stored;
  int cycle_cnt;
  int stall_left;
  int hold_req;
  bit fast_mode;

  // --------------------------------------------------------------------------
  // clock, cycle limit
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_cnt, corr_q.size());
      $display("FAILURE");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // prediction
  // --------------------------------------------------------------------------
  function automatic longint sat31(longint v);
    if (v > LIM31) return LIM31;
    if (v < -LIM31) return -LIM31;
    return v;
  endfunction

  function automatic coord_t sat32(longint v);
    if (v > LIM31) return coord_t'(LIM31);
    if (v < -LIM31 - 1) return coord_t'(-LIM31 - 1);
    return coord_t'(v);
  endfunction

  // floor(n * 2^FRAC / d), 0 <= n <= d
  function automatic longint bary_frac(longint n, longint d);
    longint unsigned r, dd, q;
    r = n;
    dd = d;
    q = 0;
    if (r >= dd) begin
      q = 1;
      r -= dd;
    end
    for (int i = 0; i < FRAC; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= dd) begin
        r -= dd;
        q |= 1;
      end
    end
    return longint'(q);
  endfunction

  function automatic void store_triangle(longint rx, longint ry, longint tx, longint ty);
    longint e00, e10, e01, e11, det;
    int k;
    k = tri_count;
    if (k >= N_TRI) return;
    e00 = sat31(pend_ref[1][0] - pend_ref[0][0]);
    e10 = sat31(pend_ref[1][1] - pend_ref[0][1]);
    e01 = sat31(rx - pend_ref[0][0]);
    e11 = sat31(ry - pend_ref[0][1]);
    det = e00 * e11 - e01 * e10;
    if (det == 0) return;     // singular, not stored
    ro[k][0] = pend_ref[0][0];
    ro[k][1] = pend_ref[0][1];
    inv0[k][0] = e11;
    inv0[k][1] = -e01;
    inv1[k][0] = -e10;
    inv1[k][1] = e00;
    det_t[k] = det;
    tgo[k][0] = pend_tgt[0][0];
    tgo[k][1] = pend_tgt[0][1];
    te0[k][0] = sat31(pend_tgt[1][0] - pend_tgt[0][0]);
    te0[k][1] = sat31(pend_tgt[1][1] - pend_tgt[0][1]);
    te1[k][0] = sat31(tx - pend_tgt[0][0]);
    te1[k][1] = sat31(ty - pend_tgt[0][1]);
    tri_count = k + 1;
    n_stored++;
  endfunction

  function automatic void correct_point(longint px, longint py);
    longint sx, sy, dx, dy, n0, n1, d, l0, l1;
    int hits;
    corr_t c;
    sx = 0;
    sy = 0;
    hits = 0;
    for (int k = 0; k < tri_count; k++) begin
      dx = sat31(px - ro[k][0]);
      dy = sat31(py - ro[k][1]);
      n0 = inv0[k][0] * dx + inv0[k][1] * dy;
      n1 = inv1[k][0] * dx + inv1[k][1] * dy;
      d  = det_t[k];
      if (d < 0) begin
        d = -d;
        n0 = -n0;
        n1 = -n1;
      end
      if (n0 < 0 || n1 < 0 || n0 > d || n1 > d || n0 > d - n1) continue;
      l0 = bary_frac(n0, d);
      l1 = bary_frac(n1, d);
      // arithmetic shift is the floor
      sx += tgo[k][0] + ((te0[k][0] * l0 + te1[k][0] * l1) >>> FRAC);
      sy += tgo[k][1] + ((te0[k][1] * l0 + te1[k][1] * l1) >>> FRAC);
      hits++;
    end
    if (hits == 0) begin
      c.x = sat32(px);
      c.y = sat32(py);
    end else begin
      c.x = sat32(sx / hits);   // truncates toward zero
      c.y = sat32(sy / hits);
      n_hit_queries++;
    end
    c.hits = hits[6:0];
    c.size = tri_count[6:0];
    corr_q.insert(corr_q.size(), c);
  endfunction

  function automatic void predict_word(logic [1:0] kind, logic [1:0] vi, coord_t rx,
                                       coord_t ry, coord_t tx, coord_t ty,
                                       coord_t px, coord_t py);
    case (kind)
      tmpc_pkg::KIND_CLEAR: tri_count = 0;
      tmpc_pkg::KIND_LOAD: begin
        n_loads++;
        if (vi < tmpc_pkg::VTX_LAST) begin
          pend_ref[vi][0] = longint'(rx);
          pend_ref[vi][1] = longint'(ry);
          pend_tgt[vi][0] = longint'(tx);
          pend_tgt[vi][1] = longint'(ty);
        end else if (vi == tmpc_pkg::VTX_LAST) begin
          store_triangle(longint'(rx), longint'(ry), longint'(tx), longint'(ty));
        end
      end
      tmpc_pkg::KIND_QUERY: begin
        n_queries++;
        correct_point(longint'(px), longint'(py));
      end
      default: ;  // kind 3 ignored
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // input side: one word per call, random gap first
  // --------------------------------------------------------------------------
  task automatic send_word(logic [1:0] kind, logic [1:0] vi, coord_t rx, coord_t ry,
                           coord_t tx, coord_t ty, coord_t px, coord_t py);
    int gap;
    gap = fast_mode ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.kind = kind;
    in_ch.vertex_index = vi;
    in_ch.ref_x = rx;
    in_ch.ref_y = ry;
    in_ch.target_x = tx;
    in_ch.target_y = ty;
    in_ch.point_x = px;
    in_ch.point_y = py;
    in_ch.valid = 1'b1;
    forever begin
      @(posedge clk);
      if (in_ch.ready) break;
    end
    predict_word(kind, vi, rx, ry, tx, ty, px, py);
    @(negedge clk);
  endtask

  task automatic load_vtx(logic [1:0] vi, coord_t rx, coord_t ry, coord_t tx, coord_t ty);
    send_word(tmpc_pkg::KIND_LOAD, vi, rx, ry, tx, ty, coord_t'($urandom),
              coord_t'($urandom));
  endtask

  task automatic query(coord_t px, coord_t py);
    send_word(tmpc_pkg::KIND_QUERY, 2'($urandom), coord_t'($urandom), coord_t'($urandom),
              coord_t'($urandom), coord_t'($urandom), px, py);
  endtask

  task automatic clear_tab();
    send_word(tmpc_pkg::KIND_CLEAR, 2'($urandom), coord_t'($urandom), coord_t'($urandom),
              coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
              coord_t'($urandom));
  endtask

  // sender waits for every result, then for a possible trailing load
  task automatic drain();
    in_ch.valid = 1'b0;
    while (corr_q.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // result side: ready with random stalls, long hold-off on request
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready = 1'b0;
    end else if (hold_req > 0) begin
      out_ch.ready = 1'b0;
      hold_req--;
    end else if (stall_left > 0) begin
      out_ch.ready = 1'b0;
      stall_left--;
    end else begin
      out_ch.ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    corr_t c;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_results++;
      stall_left = fast_mode ? 0 : $urandom_range(0, 7);
      if (corr_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("unexpected result word: x=%0d y=%0d hits=%0d size=%0d",
                   out_ch.out_x, out_ch.out_y, out_ch.hit_count, out_ch.table_size);
      end else begin
        c = corr_q.pop_front();
        if (out_ch.out_x !== c.x || out_ch.out_y !== c.y ||
            out_ch.hit_count !== c.hits || out_ch.table_size !== c.size) begin
          n_mismatch++;
          if (n_mismatch <= 10) begin
            $display("mismatch on result %0d: exp x=%0d y=%0d hits=%0d size=%0d",
                     n_results, c.x, c.y, c.hits, c.size);
            $display("  got x=%0d y=%0d hits=%0d size=%0d", out_ch.out_x,
                     out_ch.out_y, out_ch.hit_count, out_ch.table_size);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  function automatic coord_t near(longint base, int span);
    return coord_t'(base + longint'($urandom_range(0, 2 * span)) - span);
  endfunction

  task automatic test_directed();
    coord_t q1;
    q1 = coord_t'(ONE_Q);
    query(32'sh7fffffff, 32'sh80000000);      // empty table, extremes pass through
    // unit triangle, targets shifted by (5,-3) and scaled by 2
    load_vtx(0, 0, 0, 5 * q1, -3 * q1);
    load_vtx(1, q1, 0, 7 * q1, -3 * q1);
    load_vtx(2, 0, q1, 5 * q1, -q1);
    query(0, 0);                              // at a vertex
    query(q1 / 4, q1 / 4);                    // inside
    query(q1 / 2, q1 / 2);                    // on the hypotenuse, sum exactly 1
    query(q1, q1);                            // outside
    query(-1, 0);                             // just outside
    // same triangle in opposite winding: negative determinant, two hits
    load_vtx(0, 0, 0, 5 * q1, -3 * q1);
    load_vtx(1, 0, q1, 5 * q1, -q1);
    load_vtx(2, q1, 0, 7 * q1, -3 * q1);
    query(q1 / 3, q1 / 5);
    // collinear, not stored
    load_vtx(2, 0, 2 * q1, 0, 0);
    // edge differences saturate
    load_vtx(0, 32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh80000000);
    load_vtx(1, 32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff);
    load_vtx(2, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh80000000);
    query(32'sh7fffffff, 32'sh7fffffff);
    query(32'sh80000000, 32'sh80000000);
    // ignored words
    send_word(2'd3, 0, 1, 2, 3, 4, 5, 6);
    load_vtx(2'd3, q1, q1, q1, q1);
    query(q1 / 8, q1 / 8);
    clear_tab();
    query(q1 / 8, q1 / 8);
    drain();
  endtask

  // pending vertices persist, so repeated vertex 2 words fill the table
  task automatic test_table_full();
    coord_t q1;
    q1 = coord_t'(ONE_Q);
    clear_tab();
    load_vtx(0, 0, 0, 0, 0);
    load_vtx(1, 4 * q1, 0, 8 * q1, 0);
    for (int i = 0; i < N_TRI + 2; i++)
      load_vtx(2, near(0, 1000), 4 * q1 + i * 64, near(0, 1 << 20), 8 * q1);
    query(q1, q1);
    query(near(2 * q1, 1 << 17), near(q1, 1 << 17));
    query(32'sh7fffffff, 32'sh80000000);
    clear_tab();
    query(q1, q1);
    drain();
  endtask

  task automatic test_random(int n_words);
    longint bx, by;
    int r, sent;
    sent = 0;
    bx = 0;
    by = 0;
    while (sent < n_words) begin
      if (($urandom_range(0, 199) == 0))
        fast_mode = ~fast_mode;   // stretches without any idling
      r = $urandom_range(0, 99);
      if (r < 3 || (tri_count > 10 && r < 12)) begin
        clear_tab();
        bx = longint'($urandom_range(0, 1 << 24)) - (1 << 23);
        by = longint'($urandom_range(0, 1 << 24)) - (1 << 23);
        sent++;
      end else if (r < 45) begin
        // well-formed triangle around the current area
        load_vtx(0, near(bx, 1 << 18), near(by, 1 << 18), near(bx, 1 << 19),
                 near(by, 1 << 19));
        load_vtx(1, near(bx, 1 << 18), near(by, 1 << 18), near(bx, 1 << 19),
                 near(by, 1 << 19));
        load_vtx(2, near(bx, 1 << 18), near(by, 1 << 18), near(bx, 1 << 19),
                 near(by, 1 << 19));
        sent += 3;
      end else if (r < 88) begin
        query(near(bx, 1 << 18), near(by, 1 << 18));
        sent++;
      end else begin
        // noise: any kind, any vertex, full-range fields
        send_word(2'($urandom), 2'($urandom), coord_t'($urandom), coord_t'($urandom),
                  coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                  coord_t'($urandom));
        sent++;
      end
    end
    fast_mode = 1'b0;
    drain();
  endtask

  // result side holds off while words keep coming, so the block backs up
  task automatic test_backpressure();
    coord_t q1;
    q1 = coord_t'(ONE_Q);
    clear_tab();
    load_vtx(0, 0, 0, q1, q1);
    load_vtx(1, 2 * q1, 0, 3 * q1, q1);
    load_vtx(2, 0, 2 * q1, q1, 3 * q1);
    hold_req = 600;
    fast_mode = 1'b1;
    for (int i = 0; i < 20; i++)
      query(near(q1 / 2, 1 << 16), near(q1 / 2, 1 << 16));
    fast_mode = 1'b0;
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.kind = tmpc_pkg::KIND_CLEAR;
    in_ch.vertex_index = '0;
    in_ch.ref_x = '0;
    in_ch.ref_y = '0;
    in_ch.target_x = '0;
    in_ch.target_y = '0;
    in_ch.point_x = '0;
    in_ch.point_y = '0;
    out_ch.ready = 1'b0;
    tri_count = 0;
    n_mismatch = 0;
    n_results = 0;
    n_queries = 0;
    n_hit_queries = 0;
    n_loads = 0;
    n_stored = 0;
    cycle_cnt = 0;
    stall_left = 0;
    hold_req = 0;
    fast_mode = 1'b0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed();
    test_table_full();
    test_backpressure();
    test_random(730);
    repeat (200) @(negedge clk);

    $display("covered %0d queries (%0d with hits), %0d loads, %0d triangles stored",
             n_queries, n_hit_queries, n_loads, n_stored);
    $display("%0d result words checked, %0d mismatches", n_results, n_mismatch);
    if (n_mismatch == 0 && corr_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
